>>> src/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg
// Shared constants, state encodings and status types for the sliding window
// average block.
// ----------------------------------------------------------------------------
package swa_pkg;

  localparam int unsigned WindowMaxDef  = 64;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned FracBits      = 8;
  localparam int unsigned WindowReset   = 8;
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [0:0] {
    F_IDLE,
    F_UPDATE
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DONE
  } back_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

>>> src/sliding_window_average.sv
// ----------------------------------------------------------------------------
// sliding_window_average
// Moving average over the last window_size samples, Q.8 result truncated
// toward zero, with the divisor reported alongside.
// ----------------------------------------------------------------------------
// Flow: the front end registers the sample and then pushes sum and divisor,
//   the divider pops the queue and runs AVG_W (24) divider steps, and the
//   result is held until taken. The divider is one-bit-per-cycle; the front
//   end takes no new sample until the last one is pushed to the queue.
// Reset: control state cleared, window size 8, empty window; no ring clear
//   pass is needed, unwritten slots read as zero through the fill count.
module sliding_window_average #(
  parameter int unsigned WINDOW_MAX  = swa_pkg::WindowMaxDef,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SampleBitsDef,
  localparam int unsigned SLOT_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
  localparam int unsigned CNT_W      = $clog2(WINDOW_MAX + 1),
  localparam int unsigned SUM_W      = SAMPLE_BITS + SLOT_W,
  localparam int unsigned AVG_W      = SAMPLE_BITS + swa_pkg::FracBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CNT_W-1:0]       cfg_window_size_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [AVG_W-1:0]       average_o,
  output logic [CNT_W-1:0]       samples_in_window_o
);

  localparam int unsigned JOB_W = SUM_W + CNT_W;

  swa_pkg::queue_stat_t queue_stat;
  logic                 push;
  logic [SUM_W-1:0]     push_sum;
  logic [CNT_W-1:0]     push_count;
  logic                 pop;
  logic [JOB_W-1:0]     pop_data;

  swa_front #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_window_size_i (cfg_window_size_i),
    .in_valid_i        (in_valid_i),
    .sample_i          (sample_i),
    .in_stall_o        (in_stall_o),
    .queue_stat_i      (queue_stat),
    .push_o            (push),
    .push_sum_o        (push_sum),
    .push_count_o      (push_count)
  );

  swa_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_sum, push_count}),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (queue_stat)
  );

  swa_div #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .queue_stat_i        (queue_stat),
    .job_sum_i           (pop_data[JOB_W-1:CNT_W]),
    .job_count_i         (pop_data[CNT_W-1:0]),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .average_o           (average_o),
    .samples_in_window_o (samples_in_window_o)
  );

endmodule

>>> src/swa_ram.sv
// ----------------------------------------------------------------------------
// swa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/swa_front.sv
// ----------------------------------------------------------------------------
// swa_front
// Front end: accepts samples, keeps the sample ring, running sum, write slot
// and fill count, and pushes sum and divisor into the job queue.
// ----------------------------------------------------------------------------
module swa_front #(
  parameter int unsigned WINDOW_MAX  = swa_pkg::WindowMaxDef,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SampleBitsDef,
  localparam int unsigned SLOT_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
  localparam int unsigned CNT_W      = $clog2(WINDOW_MAX + 1),
  localparam int unsigned SUM_W      = SAMPLE_BITS + SLOT_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CNT_W-1:0]        cfg_window_size_i,
  input  logic                    in_valid_i,
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  output logic                    in_stall_o,
  input  swa_pkg::queue_stat_t    queue_stat_i,
  output logic                    push_o,
  output logic [SUM_W-1:0]        push_sum_o,
  output logic [CNT_W-1:0]        push_count_o
);

  localparam logic [CNT_W-1:0] WinMax   = CNT_W'(WINDOW_MAX);
  localparam logic [CNT_W-1:0] WinReset =
    CNT_W'((swa_pkg::WindowReset > WINDOW_MAX) ? WINDOW_MAX : swa_pkg::WindowReset);

  swa_pkg::front_state_e state_q, state_d;

  logic [CNT_W-1:0]       win_q;
  logic [CNT_W-1:0]       fill_q, fill_d;
  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [CNT_W-1:0]       cfg_win;
  logic [CNT_W-1:0]       slot_next;
  logic                   accept;
  logic                   commit;

  assign accept = in_valid_i && !in_stall_o;

  swa_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (slot_q),
    .wdata_i (sample_q),
    .re_i    (accept),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (cfg_window_size_i == '0) begin
      cfg_win = CNT_W'(1);
    end else if (cfg_window_size_i > WinMax) begin
      cfg_win = WinMax;
    end else begin
      cfg_win = cfg_window_size_i;
    end
  end

  always_comb begin
    old_sample = (fill_q < win_q) ? '0 : ram_rdata;
    sum_d      = sum_q - {{SLOT_W{old_sample[SAMPLE_BITS-1]}}, old_sample}
                       + {{SLOT_W{sample_q[SAMPLE_BITS-1]}}, sample_q};
    slot_next  = CNT_W'(slot_q) + CNT_W'(1);
    slot_d     = (slot_next >= win_q) ? '0 : SLOT_W'(slot_next);
    fill_d     = (fill_q < win_q) ? fill_q + CNT_W'(1) : fill_q;
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    commit     = 1'b0;
    unique case (state_q)
      swa_pkg::F_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = swa_pkg::F_UPDATE;
        end
      end
      swa_pkg::F_UPDATE: begin
        if (!queue_stat_i.full) begin
          commit  = 1'b1;
          state_d = swa_pkg::F_IDLE;
        end
      end
      default: state_d = swa_pkg::F_IDLE;
    endcase
  end

  assign push_o       = commit;
  assign push_sum_o   = sum_d;
  assign push_count_o = fill_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swa_pkg::F_IDLE;
      win_q   <= WinReset;
      fill_q  <= '0;
      slot_q  <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        win_q  <= cfg_win;
        fill_q <= '0;
        slot_q <= '0;
        sum_q  <= '0;
      end else if (commit) begin
        fill_q <= fill_d;
        slot_q <= slot_d;
        sum_q  <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
    end
  end

endmodule

>>> src/swa_queue.sv
// ----------------------------------------------------------------------------
// swa_queue
// Short job queue between the front end and the divider.
// ----------------------------------------------------------------------------
module swa_queue #(
  parameter int unsigned WIDTH = 29,
  localparam int unsigned DEPTH = swa_pkg::QueueDepth,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [WIDTH-1:0]     push_data_i,
  input  logic                 pop_i,
  output logic [WIDTH-1:0]     pop_data_o,
  output swa_pkg::queue_stat_t stat_o
);

  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W:0]   Full    = (PTR_W + 1)'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == Full);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (PTR_W + 1)'(1);
        2'b01:   cnt_q <= cnt_q - (PTR_W + 1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> src/swa_div.sv
// ----------------------------------------------------------------------------
// swa_div
// Back end: bit-serial restoring divider producing the Q.8 mean, truncated
// toward zero, and the result register.
// ----------------------------------------------------------------------------
module swa_div #(
  parameter int unsigned WINDOW_MAX  = swa_pkg::WindowMaxDef,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SampleBitsDef,
  localparam int unsigned SLOT_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
  localparam int unsigned CNT_W      = $clog2(WINDOW_MAX + 1),
  localparam int unsigned SUM_W      = SAMPLE_BITS + SLOT_W,
  localparam int unsigned AVG_W      = SAMPLE_BITS + swa_pkg::FracBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swa_pkg::queue_stat_t queue_stat_i,
  input  logic [SUM_W-1:0]     job_sum_i,
  input  logic [CNT_W-1:0]     job_count_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [AVG_W-1:0]     average_o,
  output logic [CNT_W-1:0]     samples_in_window_o
);

  localparam int unsigned DIV_W  = SUM_W + swa_pkg::FracBits;
  localparam int unsigned STEP_W = (AVG_W > 1) ? $clog2(AVG_W) : 1;
  localparam logic [STEP_W-1:0] LastStep = STEP_W'(AVG_W - 1);

  swa_pkg::back_state_e state_q, state_d;

  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [AVG_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  div_q;
  logic              neg_q;
  logic [STEP_W-1:0] step_q;
  logic [AVG_W-1:0]  avg_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [SUM_W-1:0]  mag;
  logic [DIV_W-1:0]  dividend;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic              load;
  logic              finish;

  always_comb begin
    mag      = job_sum_i[SUM_W-1] ? (~job_sum_i + SUM_W'(1)) : job_sum_i;
    dividend = {mag, {swa_pkg::FracBits{1'b0}}};
    trial    = {rem_q, quo_q[AVG_W-1]};
    ge       = (trial >= {1'b0, div_q});
    rem_d    = ge ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
    quo_d    = {quo_q[AVG_W-2:0], ge};
  end

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    finish  = 1'b0;
    unique case (state_q)
      swa_pkg::B_IDLE: begin
        if (!queue_stat_i.empty) begin
          load    = 1'b1;
          state_d = swa_pkg::B_RUN;
        end
      end
      swa_pkg::B_RUN: begin
        if (step_q == '0) begin
          finish  = 1'b1;
          state_d = swa_pkg::B_DONE;
        end
      end
      swa_pkg::B_DONE: begin
        if (!out_stall_i) begin
          state_d = swa_pkg::B_IDLE;
        end
      end
      default: state_d = swa_pkg::B_IDLE;
    endcase
  end

  assign pop_o               = load;
  assign out_valid_o         = (state_q == swa_pkg::B_DONE);
  assign average_o           = avg_q;
  assign samples_in_window_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swa_pkg::B_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        step_q <= LastStep;
      end else if (state_q == swa_pkg::B_RUN) begin
        step_q <= step_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q <= CNT_W'(dividend[DIV_W-1:AVG_W]);
      quo_q <= dividend[AVG_W-1:0];
      div_q <= job_count_i;
      neg_q <= job_sum_i[SUM_W-1];
    end else if (state_q == swa_pkg::B_RUN) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (finish) begin
      avg_q <= neg_q ? (~quo_d + AVG_W'(1)) : quo_d;
      cnt_q <= div_q;
    end
  end

endmodule

>>> src/swa_checker.sv
// ----------------------------------------------------------------------------
// swa_checker
// Port-level checks for the sliding window average block.
// ----------------------------------------------------------------------------
module swa_checker #(
  parameter int unsigned WINDOW_MAX  = swa_pkg::WindowMaxDef,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SampleBitsDef,
  localparam int unsigned CNT_W      = $clog2(WINDOW_MAX + 1),
  localparam int unsigned AVG_W      = SAMPLE_BITS + swa_pkg::FracBits
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [AVG_W-1:0]       average_o,
  input logic [CNT_W-1:0]       samples_in_window_o
);

  localparam logic [CNT_W-1:0] WinMax = CNT_W'(WINDOW_MAX);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(average_o)
      && $stable(samples_in_window_o))
    else $error("result transaction dropped or changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (samples_in_window_o != '0) && (samples_in_window_o <= WinMax))
    else $error("divisor outside 1..WINDOW_MAX");

  a_single_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (samples_in_window_o == CNT_W'(1))
      |-> (average_o[swa_pkg::FracBits-1:0] == '0))
    else $error("mean of one sample has a fractional part");

  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("front end took a second transaction while updating");

endmodule

bind sliding_window_average swa_checker #(
  .WINDOW_MAX  (WINDOW_MAX),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_swa_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .average_o           (average_o),
  .samples_in_window_o (samples_in_window_o)
);

>>> dv/sliding_window_average_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_average_tb
// Self-checking bench for the moving average block. Samples are queued by a
// stimulus thread, driven with random gaps, and each one is folded into a
// local copy of the window to predict the Q.8 mean and divisor. Results are
// collected under random back-pressure and compared in order. The window size
// is reprogrammed between drained phases, including clamped values.
// ----------------------------------------------------------------------------
module sliding_window_average_tb;

  localparam int unsigned WinMax  = swa_pkg::WindowMaxDef;
  localparam int unsigned SampleW = swa_pkg::SampleBitsDef;
  localparam int unsigned CountW  = $clog2(WinMax + 1);
  localparam int unsigned SlotW   = $clog2(WinMax);
  localparam int unsigned SumW    = SampleW + SlotW;
  localparam int unsigned AvgW    = SampleW + swa_pkg::FracBits;
  localparam int unsigned RandomItems = 900;
  localparam int unsigned RxHoldCycles = 400;
  localparam longint unsigned CycleLimit = 1000000;

  localparam logic [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};

  typedef struct packed {
    logic signed [AvgW-1:0] average;
    logic [CountW-1:0]      count;
  } mean_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CountW-1:0]   cfg_window_size_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [SampleW-1:0]  sample_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [AvgW-1:0]     average_o;
  logic [CountW-1:0]   samples_in_window_o;

  logic [SampleW-1:0]        pending_samples[$];
  mean_t                     mean_due_q[$];
  mean_t                     head_mean;

  logic signed [SampleW-1:0] window_store[WinMax];
  logic signed [SumW-1:0]    window_sum;
  logic [CountW-1:0]         next_slot;
  logic [CountW-1:0]         seen_count;
  logic [CountW-1:0]         span;

  logic                      calm = 1'b0;
  logic                      rx_hold_go = 1'b0;
  int unsigned               rx_hold_left = 0;
  int unsigned               err_count = 0;
  int unsigned               items_accepted = 0;
  int unsigned               means_checked = 0;
  int unsigned               settings_used = 0;
  longint unsigned           cycle_count = 0;

  sliding_window_average DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_window_size_i   (cfg_window_size_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .sample_i            (sample_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .average_o           (average_o),
    .samples_in_window_o (samples_in_window_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic load_window_size(input logic [CountW-1:0] value);
    if (value == 0) begin
      span = CountW'(1);
    end else if (value > WinMax) begin
      span = CountW'(WinMax);
    end else begin
      span = value;
    end
    foreach (window_store[i]) window_store[i] = '0;
    window_sum = '0;
    next_slot  = '0;
    seen_count = '0;
  endtask

  task automatic advance_window(input logic signed [SampleW-1:0] smp);
    logic [CountW-1:0] slot;
    longint            quot;
    mean_t             m;
    slot = next_slot;
    if (slot >= span) slot = '0;
    window_sum = window_sum - SumW'(window_store[slot]) + SumW'(smp);
    window_store[slot] = smp;
    slot = slot + CountW'(1);
    if (slot >= span) slot = '0;
    next_slot = slot;
    if (seen_count < span) seen_count = seen_count + CountW'(1);
    quot = (longint'(window_sum) * (longint'(1) << swa_pkg::FracBits)) / longint'(seen_count);
    m.average = quot[AvgW-1:0];
    m.count   = seen_count;
    mean_due_q.push_back(m);
  endtask

  task automatic push_samples(input int unsigned n);
    logic [SampleW-1:0] s;
    repeat (n) begin
      case ($urandom_range(9))
        0: s = SampleMax;
        1: s = SampleMin;
        2: s = SampleW'($signed($urandom_range(15)) - 8);
        default: s = SampleW'($urandom);
      endcase
      pending_samples.push_back(s);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || mean_due_q.size() != 0);
  endtask

  task automatic write_window(input logic [CountW-1:0] value);
    repeat (4) @(posedge clk_i);
    cfg_we_i          <= 1'b1;
    cfg_window_size_i <= value;
    load_window_size(value);
    settings_used++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // hold the sample until the block takes it, then offer the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i   <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        advance_window(sample_i);
        items_accepted++;
      end
      if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
        in_valid_i <= 1'b1;
        sample_i   <= pending_samples.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold_left <= 0;
    end else if (rx_hold_go) begin
      rx_hold_left <= RxHoldCycles;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (mean_due_q.size() == 0) begin
          $display("%0t: unexpected transaction, average %0d divisor %0d", $time,
                   $signed(average_o), samples_in_window_o);
          err_count++;
        end else begin
          head_mean = mean_due_q.pop_front();
          means_checked++;
          if (average_o !== head_mean.average) begin
            $display("%0t: average expected %0d actual %0d", $time,
                     head_mean.average, $signed(average_o));
            err_count++;
          end
          if (samples_in_window_o !== head_mean.count) begin
            $display("%0t: samples_in_window expected %0d actual %0d", $time,
                     head_mean.count, samples_in_window_o);
            err_count++;
          end
        end
      end
      out_stall_i <= (rx_hold_left != 0) || (!calm && $urandom_range(99) < 30);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d results outstanding", $time, mean_due_q.size());
      $display("sliding_window_average_tb: errors");
      $finish;
    end
  end

  initial begin
    int unsigned       sent;
    int unsigned       n;
    int unsigned       phase;
    logic [CountW-1:0] wsz;

    load_window_size(CountW'(swa_pkg::WindowReset));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_samples = '{SampleMax, SampleMax, SampleMin, SampleMin, 16'hFFFF, 16'h0001,
                        16'h0000, 16'h5555, 16'hAAAA, SampleMin, SampleMin, SampleMin,
                        SampleMin, SampleMin, SampleMin, SampleMin, SampleMin};
    wait_drained();

    write_window('0);
    pending_samples = '{SampleMin, SampleMax, 16'h0005};
    wait_drained();

    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      case (phase)
        0: wsz = 7'd127;
        1: wsz = CountW'(WinMax);
        2: wsz = CountW'(WinMax + 1);
        3: wsz = 7'd1;
        4: wsz = 7'd2;
        5: wsz = CountW'(WinMax - 1);
        default: wsz = ($urandom_range(4) == 0) ? CountW'($urandom_range(127))
                                                 : CountW'($urandom_range(1, WinMax));
      endcase
      write_window(wsz);
      calm <= (phase == 3);
      if (phase == 0) begin
        n = 140;
        repeat (70) pending_samples.push_back(SampleMax);
        repeat (70) pending_samples.push_back(SampleMin);
      end else if (phase == 2) begin
        n = $urandom_range(30, 110);
        push_samples(n / 2);
        wait_drained();
        push_samples(n - n / 2);
      end else begin
        n = (phase == 3) ? 110 : $urandom_range(30, 110);
        push_samples(n);
        if (phase == 1) begin
          @(posedge clk_i);
          rx_hold_go <= 1'b1;
          @(posedge clk_i);
          rx_hold_go <= 1'b0;
        end
      end
      sent += n;
      wait_drained();
      phase++;
    end

    repeat (60) @(posedge clk_i);
    $display("Window settings exercised: %0d, including clamped zero and oversize writes.",
             settings_used + 1);
    $display("Samples accepted: %0d, averages checked: %0d.", items_accepted, means_checked);
    if (err_count == 0) begin
      $display("sliding_window_average_tb: clean");
    end else begin
      $display("sliding_window_average_tb: errors");
    end
    $finish;
  end

endmodule

>>> sliding_window_average.f
src/swa_pkg.sv
src/swa_ram.sv
src/swa_front.sv
src/swa_queue.sv
src/swa_div.sv
src/sliding_window_average.sv
src/swa_checker.sv
dv/sliding_window_average_tb.sv
